[hw/rtl/nvrlw_pkg.sv]
package nvrlw_pkg;

  // Request codes
  localparam logic [1:0] REQ_SAVE   = 2'd0;
  localparam logic [1:0] REQ_FORMAT = 2'd1;
  localparam logic [1:0] REQ_RESUME = 2'd2;
  localparam logic [1:0] REQ_WEAR   = 2'd3;

  // Flash operation codes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_ERASE  = 2'd1;
  localparam logic [1:0] OP_REJECT = 2'd2;
  localparam logic [1:0] OP_ACK    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_FIRST_BLOCK    = 2'd0;
  localparam logic [1:0] CFG_LAST_BLOCK     = 2'd1;
  localparam logic [1:0] CFG_FORMAT_VERSION = 2'd2;

  localparam logic [6:0] RST_FIRST_BLOCK    = 7'd96;
  localparam logic [6:0] RST_LAST_BLOCK     = 7'd126;
  localparam logic [7:0] RST_FORMAT_VERSION = 8'd1;

  localparam logic [6:0]  LOW_BLOCK  = 7'd96;
  localparam logic [6:0]  HIGH_BLOCK = 7'd126;
  localparam logic [16:0] BASE_ADDR  = 17'h18000;

  // Header contents
  localparam logic [7:0] HDR_E      = 8'h45;
  localparam logic [7:0] HDR_F      = 8'h46;
  localparam logic [7:0] HDR_L      = 8'h4C;
  localparam logic [7:0] COUNT_MARK = 8'hFE;

  localparam logic [16:0] DISCARD_OFFSET = 17'd3;
  localparam logic [16:0] USAGE_OFFSET   = 17'd4;
  localparam logic [10:0] FRESH_INDEX    = 11'd8;
  localparam logic [10:0] RECORD_STEP    = 11'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  ram_offset;
    logic [7:0]  data_value;
    logic [6:0]  block_number;
    logic [10:0] resume_index;
    logic [23:0] wear_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  flash_op;
    logic [16:0] flash_address;
    logic [2:0]  byte_count;
    logic [7:0]  data_byte0;
    logic [7:0]  data_byte1;
    logic [7:0]  data_byte2;
    logic [7:0]  data_byte3;
    logic        save_all_request;
    logic        last_result;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REJECT,
    ST_RESUME,
    ST_WEAR_LOAD,
    ST_DISCARD,
    ST_ERASE,
    ST_HEADER,
    ST_COUNT,
    ST_PAGE,
    ST_RECORD
  } state_t;

  typedef enum logic [3:0] {
    K_NONE,
    K_REJECT,
    K_RESUME,
    K_WEAR_LOAD,
    K_DISCARD,
    K_ERASE,
    K_HEADER,
    K_COUNT,
    K_PAGE,
    K_RECORD
  } kind_t;

  typedef struct packed {
    logic  load;
    logic  emit;
    kind_t kind;
    logic  last;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       cur_ok;
    logic       blk_ok;
    logic       off_ok;
    logic       ridx_ok;
    logic       wear_ok;
    logic       full;
    logic       page_hit;
  } status_t;

  function automatic logic [16:0] block_base(input logic [6:0] blk);
    logic [6:0] rel;
    rel = blk - LOW_BLOCK;
    return BASE_ADDR + {rel, 10'b0};
  endfunction

endpackage

[hw/rtl/nvrlw_ctrl.sv]
module nvrlw_ctrl
  import nvrlw_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  status_t status,
  output logic    busy,
  output cmd_t    cmd
);

  state_t state, state_next;
  logic   fmt_req;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      fmt_req <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        fmt_req <= (status.req_type == REQ_FORMAT);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (status.req_type)
            REQ_SAVE: begin
              if (!(status.cur_ok && status.off_ok)) state_next = ST_REJECT;
              else if (status.full)                 state_next = ST_DISCARD;
              else if (status.page_hit)             state_next = ST_PAGE;
              else                                  state_next = ST_RECORD;
            end
            REQ_FORMAT: state_next = status.blk_ok ? ST_ERASE : ST_REJECT;
            REQ_RESUME: state_next = (status.blk_ok && status.ridx_ok) ? ST_RESUME : ST_REJECT;
            REQ_WEAR:   state_next = status.wear_ok ? ST_WEAR_LOAD : ST_REJECT;
            default:    state_next = ST_REJECT;
          endcase
        end
      end
      ST_DISCARD: state_next = ST_ERASE;
      ST_ERASE:   state_next = ST_HEADER;
      ST_HEADER:  state_next = ST_COUNT;
      ST_COUNT:   state_next = fmt_req ? ST_IDLE : ST_RECORD;
      ST_PAGE:    state_next = ST_RECORD;
      ST_REJECT, ST_RESUME, ST_WEAR_LOAD, ST_RECORD: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != ST_IDLE);
    cmd.load = accept;
    cmd.emit = (state != ST_IDLE);
    cmd.last = 1'b0;
    cmd.kind = K_NONE;
    unique case (state)
      ST_IDLE:      cmd.kind = K_NONE;
      ST_REJECT:    begin cmd.kind = K_REJECT;    cmd.last = 1'b1; end
      ST_RESUME:    begin cmd.kind = K_RESUME;    cmd.last = 1'b1; end
      ST_WEAR_LOAD: begin cmd.kind = K_WEAR_LOAD; cmd.last = 1'b1; end
      ST_DISCARD:   cmd.kind = K_DISCARD;
      ST_ERASE:     cmd.kind = K_ERASE;
      ST_HEADER:    cmd.kind = K_HEADER;
      ST_COUNT:     begin cmd.kind = K_COUNT;     cmd.last = fmt_req; end
      ST_PAGE:      cmd.kind = K_PAGE;
      ST_RECORD:    begin cmd.kind = K_RECORD;    cmd.last = 1'b1; end
      default:      cmd.kind = K_NONE;
    endcase
  end

endmodule

[hw/rtl/nvrlw_dp.sv]
module nvrlw_dp
  import nvrlw_pkg::*;
#(
  parameter int NUM_BLOCKS  = 32,
  parameter int BLOCK_BYTES = 1024,
  parameter int RAM_BYTES   = 192
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       request,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  cmd_t       cmd,
  output status_t    status,
  output logic       result_strobe,
  output result_t    result
);

  localparam int         WIDX_W     = $clog2(NUM_BLOCKS);
  localparam logic [6:0] TOP_BLOCK  = 7'(96 + NUM_BLOCKS - 1);
  localparam logic [6:0] WEAR_HI    = (TOP_BLOCK < HIGH_BLOCK) ? TOP_BLOCK : HIGH_BLOCK;
  localparam logic [10:0] BLK_BYTES = 11'(BLOCK_BYTES);
  localparam logic [8:0] RAM_LIMIT  = 9'(RAM_BYTES);

  // config
  logic [6:0] first_block;
  logic [6:0] last_block;
  logic [7:0] format_version;

  // log state
  logic [6:0]  current_block;
  logic [10:0] log_index;
  logic [23:0] wear_table [NUM_BLOCKS];

  // latched request
  logic [7:0]  off_q;
  logic [7:0]  val_q;
  logic [6:0]  blk_q;
  logic [10:0] ridx_q;
  logic [23:0] wear_q;
  logic        raise_q;
  logic [6:0]  fmt_block;
  logic [23:0] count_q;

  logic [6:0]  use_lo, use_hi, last_cap;
  logic [7:0]  cur_inc;
  logic [6:0]  next_block;
  logic [16:0] cur_base, fmt_base;
  logic [2:0]  page;
  logic [WIDX_W-1:0] fmt_idx, blk_idx;
  logic [6:0]  fmt_rel, blk_rel;
  logic [23:0] count_next;
  result_t     res_next;

  always_comb begin
    use_lo   = (first_block < LOW_BLOCK) ? LOW_BLOCK : first_block;
    last_cap = (last_block > HIGH_BLOCK) ? HIGH_BLOCK : last_block;
    use_hi   = (last_cap > TOP_BLOCK) ? TOP_BLOCK : last_cap;

    status.req_type = request.req_type;
    status.cur_ok   = (current_block >= use_lo) && (current_block <= use_hi);
    status.blk_ok   = (request.block_number >= use_lo) && (request.block_number <= use_hi);
    status.off_ok   = {1'b0, request.ram_offset} < RAM_LIMIT;
    status.ridx_ok  = request.resume_index <= BLK_BYTES;
    status.wear_ok  = (request.block_number >= LOW_BLOCK) && (request.block_number <= WEAR_HI);
    status.full     = log_index >= BLK_BYTES;
    status.page_hit = (log_index[6:0] == 7'd0);

    cur_inc    = {1'b0, current_block} + 8'd1;
    next_block = (cur_inc > {1'b0, use_hi}) ? use_lo : cur_inc[6:0];

    cur_base = block_base(current_block);
    fmt_base = block_base(fmt_block);
    page     = log_index[9:7];

    fmt_rel    = fmt_block - LOW_BLOCK;
    blk_rel    = blk_q - LOW_BLOCK;
    fmt_idx    = fmt_rel[WIDX_W-1:0];
    blk_idx    = blk_rel[WIDX_W-1:0];
    count_next = wear_table[fmt_idx] + 24'd1;
  end

  // result formation
  always_comb begin
    res_next = '0;
    res_next.save_all_request = raise_q;
    res_next.last_result      = cmd.last;
    case (cmd.kind)
      K_REJECT: begin
        res_next.flash_op         = OP_REJECT;
        res_next.save_all_request = 1'b0;
      end
      K_RESUME, K_WEAR_LOAD: begin
        res_next.flash_op         = OP_ACK;
        res_next.save_all_request = 1'b0;
      end
      K_DISCARD: begin
        res_next.flash_op      = OP_WRITE;
        res_next.flash_address = cur_base + DISCARD_OFFSET;
        res_next.byte_count    = 3'd1;
      end
      K_ERASE: begin
        res_next.flash_op      = OP_ERASE;
        res_next.flash_address = fmt_base;
      end
      K_HEADER: begin
        res_next.flash_op      = OP_WRITE;
        res_next.flash_address = fmt_base;
        res_next.byte_count    = 3'd4;
        res_next.data_byte0    = HDR_E;
        res_next.data_byte1    = HDR_F;
        res_next.data_byte2    = HDR_L;
        res_next.data_byte3    = format_version;
      end
      K_COUNT: begin
        res_next.flash_op      = OP_WRITE;
        res_next.flash_address = fmt_base + USAGE_OFFSET;
        res_next.byte_count    = 3'd4;
        res_next.data_byte0    = COUNT_MARK;
        res_next.data_byte1    = count_q[23:16];
        res_next.data_byte2    = count_q[15:8];
        res_next.data_byte3    = count_q[7:0];
      end
      K_PAGE: begin
        res_next.flash_op      = OP_WRITE;
        res_next.flash_address = cur_base + USAGE_OFFSET;
        res_next.byte_count    = 3'd1;
        res_next.data_byte0    = ~(8'd1 << page);
      end
      K_RECORD: begin
        res_next.flash_op      = OP_WRITE;
        res_next.flash_address = cur_base + {6'd0, log_index};
        res_next.byte_count    = 3'd2;
        res_next.data_byte0    = off_q;
        res_next.data_byte1    = val_q;
      end
      default: res_next = '0;
    endcase
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_block    <= RST_FIRST_BLOCK;
      last_block     <= RST_LAST_BLOCK;
      format_version <= RST_FORMAT_VERSION;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FIRST_BLOCK:    first_block    <= cfg_data[6:0];
        CFG_LAST_BLOCK:     last_block     <= cfg_data[6:0];
        CFG_FORMAT_VERSION: format_version <= cfg_data;
        default: ;
      endcase
    end
  end

  // log position and wear table
  always_ff @(posedge clk) begin
    if (rst) begin
      current_block <= LOW_BLOCK;
      log_index     <= FRESH_INDEX;
      raise_q       <= 1'b0;
      result_strobe <= 1'b0;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        wear_table[i] <= '0;
      end
    end else begin
      result_strobe <= cmd.emit;
      if (cmd.load) begin
        raise_q <= (request.req_type == REQ_SAVE) && status.cur_ok && status.off_ok &&
                   (status.full || status.page_hit);
      end
      case (cmd.kind)
        K_RESUME: begin
          current_block <= blk_q;
          log_index     <= ridx_q;
        end
        K_WEAR_LOAD: wear_table[blk_idx] <= wear_q;
        K_DISCARD:   current_block <= next_block;
        K_ERASE:     wear_table[fmt_idx] <= count_next;
        K_COUNT:     log_index <= FRESH_INDEX;
        K_RECORD:    log_index <= log_index + RECORD_STEP;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      off_q     <= request.ram_offset;
      val_q     <= request.data_value;
      blk_q     <= request.block_number;
      ridx_q    <= request.resume_index;
      wear_q    <= request.wear_value;
      fmt_block <= request.block_number;
    end else if (cmd.kind == K_DISCARD) begin
      fmt_block <= next_block;
    end
    if (cmd.kind == K_ERASE) begin
      count_q <= count_next;
    end
    if (cmd.emit) begin
      result <= res_next;
    end
  end

endmodule

[hw/rtl/nv_record_log_writer_core.sv]
// Channel   | Direction | Beat taken when         | Payload
// ----------+-----------+-------------------------+--------------------------
// request   | in        | start && !busy          | request (req_t)
// result    | out       | result_strobe           | result (result_t)
// config    | in        | cfg_valid && cfg_ready  | cfg_index, cfg_data
//
// A request yielding N results (1 to 5; a block changeover is the longest) holds
// busy with one controller state per result, and the next request beat is taken
// once the controller is back in idle. Results leave the output register one per
// cycle, the first after the state register and then the output register.
// rst is synchronous, active high: position returns to block 96, index 8,
// and the wear counts clear. Results cannot be stalled; cfg_ready stays high.
module nv_record_log_writer_core
  import nvrlw_pkg::*;
#(
  parameter int NUM_BLOCKS  = 32,
  parameter int BLOCK_BYTES = 1024,
  parameter int RAM_BYTES   = 192
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  req_t       request,
  output logic       result_strobe,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  // config must only be written while idle (not enforced here), so no back-pressure needed
  assign cfg_ready = 1'b1;

  // sequencer: one state per flash command of a request
  nvrlw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // datapath: log position, wear counts, address and data formation
  nvrlw_dp #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES),
    .RAM_BYTES   (RAM_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .request       (request),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .status        (status),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

[tb/sv/nvrlw_cmd_checker.sv]
module nvrlw_cmd_checker
  import nvrlw_pkg::*;
#(
  parameter int NUM_BLOCKS  = 32,
  parameter int BLOCK_BYTES = 1024,
  parameter int RAM_BYTES   = 192
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  req_t       request,
  input  logic       result_strobe,
  input  result_t    result,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         errors,
  output int         outstanding,
  output int         requests_seen,
  output int         cmds_seen,
  output int         block_switches
);
  timeunit 1ns;
  timeprecision 1ps;

  // register copies and log position
  logic [6:0]  first_blk;
  logic [6:0]  last_blk;
  logic [7:0]  fmt_version;
  logic [6:0]  cur_blk;
  logic [10:0] log_idx;
  logic [23:0] erase_count [32];

  result_t flash_cmd_q[$];   // commands still owed by the block
  result_t new_cmds[$];      // commands of the request being planned

  function automatic int lowest_blk();
    return (first_blk < LOW_BLOCK) ? int'(LOW_BLOCK) : int'(first_blk);
  endfunction

  function automatic int highest_blk();
    int h;
    h = int'(last_blk);
    if (h > int'(HIGH_BLOCK)) h = int'(HIGH_BLOCK);
    if (h > int'(LOW_BLOCK) + NUM_BLOCKS - 1) h = int'(LOW_BLOCK) + NUM_BLOCKS - 1;
    return h;
  endfunction

  function automatic bit in_use(input logic [6:0] b);
    return (int'(b) >= lowest_blk()) && (int'(b) <= highest_blk());
  endfunction

  function automatic logic [16:0] blk_addr(input logic [6:0] b);
    logic [6:0]  rel;
    int unsigned a;
    rel = b - LOW_BLOCK;
    a   = int'(BASE_ADDR) + (int'(rel) << 10);
    return a[16:0];
  endfunction

  task automatic add_cmd(input logic [1:0] op, input logic [16:0] addr,
                         input logic [2:0] n, input logic [7:0] b0,
                         input logic [7:0] b1, input logic [7:0] b2,
                         input logic [7:0] b3);
    result_t c;
    c.flash_op         = op;
    c.flash_address    = addr;
    c.byte_count       = n;
    c.data_byte0       = b0;
    c.data_byte1       = b1;
    c.data_byte2       = b2;
    c.data_byte3       = b3;
    c.save_all_request = 1'b0;
    c.last_result      = 1'b0;
    new_cmds.push_back(c);
  endtask

  // erase, header, then bumped wear count
  task automatic format_blk(input logic [6:0] b);
    int          k;
    logic [16:0] base;
    logic [23:0] w;
    k    = int'(b - LOW_BLOCK) & 31;
    base = blk_addr(b);
    w    = erase_count[k] + 24'd1;
    erase_count[k] = w;
    add_cmd(OP_ERASE, base, 3'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    add_cmd(OP_WRITE, base, 3'd4, HDR_E, HDR_F, HDR_L, fmt_version);
    add_cmd(OP_WRITE, base + USAGE_OFFSET, 3'd4, COUNT_MARK, w[23:16], w[15:8], w[7:0]);
    log_idx = FRESH_INDEX;
  endtask

  task automatic predict_flash_cmds(input req_t r);
    bit         raise;
    logic [2:0] page;
    logic [7:0] usage;
    new_cmds.delete();
    raise = 1'b0;
    case (r.req_type)
      REQ_SAVE: begin
        if (!in_use(cur_blk) || int'(r.ram_offset) >= RAM_BYTES) begin
          add_cmd(OP_REJECT, '0, '0, '0, '0, '0, '0);
        end else begin
          if (int'(log_idx) >= BLOCK_BYTES) begin
            add_cmd(OP_WRITE, blk_addr(cur_blk) + DISCARD_OFFSET, 3'd1,
                    8'd0, 8'd0, 8'd0, 8'd0);
            cur_blk = cur_blk + 7'd1;
            if (int'(cur_blk) > highest_blk()) cur_blk = 7'(lowest_blk());
            format_blk(cur_blk);
            raise = 1'b1;
            block_switches++;
          end
          if (log_idx[6:0] == 7'd0) begin
            page  = log_idx[9:7];
            usage = ~(8'd1 << page);
            add_cmd(OP_WRITE, blk_addr(cur_blk) + USAGE_OFFSET, 3'd1,
                    usage, 8'd0, 8'd0, 8'd0);
            raise = 1'b1;
          end
          add_cmd(OP_WRITE, blk_addr(cur_blk) + 17'(log_idx), 3'd2,
                  r.ram_offset, r.data_value, 8'd0, 8'd0);
          log_idx = log_idx + RECORD_STEP;
        end
      end
      REQ_FORMAT: begin
        if (in_use(r.block_number)) format_blk(r.block_number);
        else add_cmd(OP_REJECT, '0, '0, '0, '0, '0, '0);
      end
      REQ_RESUME: begin
        if (in_use(r.block_number) && int'(r.resume_index) <= BLOCK_BYTES) begin
          cur_blk = r.block_number;
          log_idx = r.resume_index;
          add_cmd(OP_ACK, '0, '0, '0, '0, '0, '0);
        end else begin
          add_cmd(OP_REJECT, '0, '0, '0, '0, '0, '0);
        end
      end
      default: begin
        if (r.block_number >= LOW_BLOCK && r.block_number <= HIGH_BLOCK &&
            int'(r.block_number - LOW_BLOCK) < NUM_BLOCKS) begin
          erase_count[int'(r.block_number - LOW_BLOCK) & 31] = r.wear_value;
          add_cmd(OP_ACK, '0, '0, '0, '0, '0, '0);
        end else begin
          add_cmd(OP_REJECT, '0, '0, '0, '0, '0, '0);
        end
      end
    endcase
    foreach (new_cmds[i]) begin
      new_cmds[i].save_all_request = raise;
      new_cmds[i].last_result      = (i == new_cmds.size() - 1);
      flash_cmd_q.push_back(new_cmds[i]);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      first_blk   = RST_FIRST_BLOCK;
      last_blk    = RST_LAST_BLOCK;
      fmt_version = RST_FORMAT_VERSION;
      cur_blk     = LOW_BLOCK;
      log_idx     = FRESH_INDEX;
      foreach (erase_count[k]) erase_count[k] = '0;
      flash_cmd_q.delete();
      errors         = 0;
      requests_seen  = 0;
      cmds_seen      = 0;
      block_switches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FIRST_BLOCK:    first_blk   = cfg_data[6:0];
          CFG_LAST_BLOCK:     last_blk    = cfg_data[6:0];
          CFG_FORMAT_VERSION: fmt_version = cfg_data;
          default: ;
        endcase
      end
      if (result_strobe) begin
        cmds_seen++;
        if (flash_cmd_q.size() == 0) begin
          errors++;
          $display("%0t ns: result expected none actual %0h", $time, result);
        end else begin
          want = flash_cmd_q.pop_front();
          check_field("flash_op",         want.flash_op,         result.flash_op);
          check_field("flash_address",    want.flash_address,    result.flash_address);
          check_field("byte_count",       want.byte_count,       result.byte_count);
          check_field("data_byte0",       want.data_byte0,       result.data_byte0);
          check_field("data_byte1",       want.data_byte1,       result.data_byte1);
          check_field("data_byte2",       want.data_byte2,       result.data_byte2);
          check_field("data_byte3",       want.data_byte3,       result.data_byte3);
          check_field("save_all_request", want.save_all_request, result.save_all_request);
          check_field("last_result",      want.last_result,      result.last_result);
        end
      end
      if (start && !busy) begin
        requests_seen++;
        predict_flash_cmds(request);
      end
    end
    outstanding = flash_cmd_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nvrlw_pkg::*;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  req_t       request;
  logic       result_strobe;
  result_t    result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  int errors;
  int outstanding;
  int requests_seen;
  int cmds_seen;
  int block_switches;

  // no sender gaps once set, for the closing stretch
  bit quiet;
  // usable block window of the current register setting
  int win_lo;
  int win_hi;
  int settings_used;

  nv_record_log_writer_core dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .result_strobe (result_strobe),
    .result        (result),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  nvrlw_cmd_checker chk (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .request        (request),
    .result_strobe  (result_strobe),
    .result         (result),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .errors         (errors),
    .outstanding    (outstanding),
    .requests_seen  (requests_seen),
    .cmds_seen      (cmds_seen),
    .block_switches (block_switches)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop: the slowest legal run is a few tens of microseconds.
  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  function automatic req_t mk(input logic [1:0] kind, input logic [7:0] off,
                              input logic [7:0] val, input logic [6:0] blk,
                              input logic [10:0] ridx, input logic [23:0] wear);
    req_t r;
    r.req_type     = kind;
    r.ram_offset   = off;
    r.data_value   = val;
    r.block_number = blk;
    r.resume_index = ridx;
    r.wear_value   = wear;
    return r;
  endfunction

  // Any block inside the window; with an empty window any block in flash.
  function automatic logic [6:0] pick_blk();
    if (win_lo > win_hi) return 7'($urandom_range(int'(LOW_BLOCK), int'(HIGH_BLOCK)));
    return 7'($urandom_range(win_lo, win_hi));
  endfunction

  // One request beat. Called at a rising edge; start is only ever given one
  // new value per edge, so a back-to-back beat just keeps start high.
  task automatic issue(input req_t r);
    bit taken;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    // busy only moves at rising edges, so the falling edge gives a clean look
    forever begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
      if (taken) break;
    end
  endtask

  // Let every owed command come out, then a few spare cycles.
  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (busy || outstanding != 0);
    repeat (6) @(posedge clk);
  endtask

  // All three registers in one go, valid held high across the beats.
  task automatic program_regs(input logic [6:0] fb, input logic [6:0] lb,
                              input logic [7:0] ver);
    logic [1:0] idx [3];
    logic [7:0] val [3];
    bit         taken;
    idx[0] = CFG_FIRST_BLOCK;    val[0] = {1'b0, fb};
    idx[1] = CFG_LAST_BLOCK;     val[1] = {1'b0, lb};
    idx[2] = CFG_FORMAT_VERSION; val[2] = ver;
    drain();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      forever begin
        @(negedge clk);
        taken = cfg_ready;
        @(posedge clk);
        if (taken) break;
      end
    end
    cfg_valid <= 1'b0;
    win_lo = (fb < LOW_BLOCK) ? int'(LOW_BLOCK) : int'(fb);
    win_hi = (lb > HIGH_BLOCK) ? int'(HIGH_BLOCK) : int'(lb);
    settings_used++;
  endtask

  // Mostly resume-then-save runs aimed at page edges and block ends, so
  // changeovers and usage marks come often; the rest is formats, wear loads,
  // stray resumes and fully random beats.
  task automatic random_traffic(input int items);
    int          sent;
    int          n;
    logic [10:0] ridx;
    logic [7:0]  off;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          case ($urandom_range(0, 3))
            0:       ridx = 11'(1024 - 2 * $urandom_range(0, 4));
            1:       ridx = 11'(128 * $urandom_range(1, 7) - 2 * $urandom_range(0, 2));
            2:       ridx = 11'($urandom_range(1015, 1024));
            default: ridx = 11'(8 + 2 * $urandom_range(0, 507));
          endcase
          issue(mk(REQ_RESUME, 8'($urandom), 8'($urandom), pick_blk(), ridx,
                   24'($urandom)));
          n = $urandom_range(1, 6);
          for (int i = 0; i < n; i++) begin
            off = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(192, 255))
                                              : 8'($urandom_range(0, 191));
            issue(mk(REQ_SAVE, off, 8'($urandom), 7'($urandom), 11'($urandom),
                     24'($urandom)));
          end
          sent += n + 1;
        end
        6: begin
          issue(mk(REQ_FORMAT, 8'($urandom), 8'($urandom),
                   ($urandom_range(0, 3) == 0) ? 7'($urandom) : pick_blk(),
                   11'($urandom), 24'($urandom)));
          sent++;
        end
        7: begin
          issue(mk(REQ_WEAR, 8'($urandom), 8'($urandom),
                   ($urandom_range(0, 3) == 0) ? 7'($urandom) : pick_blk(),
                   11'($urandom),
                   ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : 24'($urandom)));
          sent++;
        end
        8: begin
          issue(req_t'($urandom_range(0, 3) == 0 ? 60'({$urandom, $urandom}) :
                       {2'($urandom), 58'({$urandom, $urandom})}));
          sent++;
        end
        default: begin
          issue(mk(REQ_RESUME, 8'($urandom), 8'($urandom), 7'($urandom),
                   11'($urandom), 24'($urandom)));
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    int spins;
    rst       <= 1'b1;
    start     <= 1'b0;
    request   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_FIRST_BLOCK;
    cfg_data  <= '0;
    quiet         = 1'b0;
    win_lo        = RST_FIRST_BLOCK;
    win_hi        = RST_LAST_BLOCK;
    settings_used = 1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset register values ---
    // plain records at the edges of the offset and value range
    issue(mk(REQ_SAVE, 8'd0,   8'h00, 7'd0, 11'd0, 24'd0));
    issue(mk(REQ_SAVE, 8'd191, 8'hFF, 7'd0, 11'd0, 24'd0));
    // offsets beyond backup RAM are refused
    issue(mk(REQ_SAVE, 8'd192, 8'h55, 7'd0, 11'd0, 24'd0));
    issue(mk(REQ_SAVE, 8'd255, 8'hAA, 7'd0, 11'd0, 24'd0));
    // format, then wear count wrap from all ones to zero
    issue(mk(REQ_FORMAT, 8'd0, 8'd0, 7'd96, 11'd0, 24'd0));
    issue(mk(REQ_WEAR, 8'd0, 8'd0, 7'd97, 11'd0, 24'hFFFFFF));
    issue(mk(REQ_FORMAT, 8'd0, 8'd0, 7'd97, 11'd0, 24'd0));
    // wear load, format and resume outside flash, and a resume past the block end
    issue(mk(REQ_WEAR, 8'd0, 8'd0, 7'd127, 11'd0, 24'h123456));
    issue(mk(REQ_WEAR, 8'd0, 8'd0, 7'd95,  11'd0, 24'h123456));
    issue(mk(REQ_FORMAT, 8'd0, 8'd0, 7'd127, 11'd0, 24'd0));
    issue(mk(REQ_FORMAT, 8'd0, 8'd0, 7'd0,   11'd0, 24'd0));
    issue(mk(REQ_RESUME, 8'd0, 8'd0, 7'd96,  11'd1025, 24'd0));
    issue(mk(REQ_RESUME, 8'd0, 8'd0, 7'd127, 11'd8,    24'd0));
    // a record that lands on a page edge
    issue(mk(REQ_RESUME, 8'd0, 8'd0, 7'd96, 11'd126, 24'd0));
    issue(mk(REQ_SAVE, 8'd10, 8'h11, 7'd0, 11'd0, 24'd0));
    issue(mk(REQ_SAVE, 8'd11, 8'h22, 7'd0, 11'd0, 24'd0));
    // block full on the top block: wraps back to the lowest one
    issue(mk(REQ_RESUME, 8'd0, 8'd0, 7'd126, 11'd1022, 24'd0));
    issue(mk(REQ_SAVE, 8'd20, 8'h33, 7'd0, 11'd0, 24'd0));
    issue(mk(REQ_SAVE, 8'd21, 8'h44, 7'd0, 11'd0, 24'd0));
    // page zero mark at index zero, then odd index running into full
    issue(mk(REQ_RESUME, 8'd0, 8'd0, 7'd100, 11'd0, 24'd0));
    issue(mk(REQ_SAVE, 8'd30, 8'h66, 7'd0, 11'd0, 24'd0));
    issue(mk(REQ_RESUME, 8'd0, 8'd0, 7'd100, 11'd1023, 24'd0));
    issue(mk(REQ_SAVE, 8'd31, 8'h77, 7'd0, 11'd0, 24'd0));
    issue(mk(REQ_SAVE, 8'd32, 8'h88, 7'd0, 11'd0, 24'd0));

    random_traffic(90);

    // --- narrow window, wrap among four blocks ---
    program_regs(7'd100, 7'd103, 8'hA5);
    random_traffic(70);

    // --- single top block, highest version byte ---
    program_regs(7'd126, 7'd126, 8'hFF);
    random_traffic(45);

    // --- empty window: everything but wear loads is refused ---
    program_regs(7'd120, 7'd100, 8'h80);
    random_traffic(30);

    // --- single bottom block ---
    program_regs(7'd96, 7'd96, 8'h10);
    random_traffic(45);

    // --- back to the full range, no sender gaps ---
    program_regs(RST_FIRST_BLOCK, RST_LAST_BLOCK, RST_FORMAT_VERSION);
    quiet = 1'b1;
    random_traffic(60);

    // wait for the tail, bounded
    start <= 1'b0;
    spins = 0;
    do begin
      @(negedge clk);
      spins++;
    end while ((busy || outstanding != 0) && spins < 200);
    repeat (12) @(posedge clk);

    $display("run: %0d requests, %0d flash commands, %0d block changeovers",
             requests_seen, cmds_seen, block_switches);
    $display("run: %0d register settings incl. empty and single-block windows",
             settings_used);
    if (errors == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
